FILE: rtl/b2da_pkg.sv
`timescale 1ns / 1ps

package b2da_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int MAX_DIGITS_DEF = 10;

    localparam int CHAR_W   = 6;
    localparam int DCOUNT_W = 4;
    localparam int SPACE_W  = 7;

    localparam logic [SPACE_W-1:0] SPACE_RESET = 7'd64;
    localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 6'd48;

    // Commands from the sequencer to the BCD datapath
    typedef struct packed {
        logic load;         // take a new binary value, clear the BCD digits
        logic shift_bit;    // one double-dabble step
        logic shift_digit;  // drop the top digit, move the rest up
    } t_bcd_ctrl;

endpackage

FILE: rtl/binary_to_decimal_ascii.sv
`timescale 1ns / 1ps
// Unsigned binary to decimal ASCII text, most significant digit first.
//
// Input channel i_valid / o_ready carries one value per item. Output channel
// o_valid / i_ready carries one result item per digit character, each with the
// total digit count and is_last on the final digit. If the digit count is
// above the space limit register or above MAX_DIGITS, one overflow item (char
// '0', count 0, is_last 1, overflow 1) is given instead. The user must write
// the register with i_cfg_we / i_cfg_data only while idle (not enforced).
//
// Timing: the value is converted by double dabble one bit per cycle, then
// leading zero digits are dropped one per cycle and a final step checks the
// count. The first result is loaded into the output register once it is free,
// and the rest follow one per cycle while i_ready is high. A new value is taken
// as soon as the last result sits in the output register.
// While i_ready is low the output register holds its item and the sequencer
// waits. Synchronous reset empties the output and sets the space limit to 64.
module binary_to_decimal_ascii #(
    parameter int VALUE_BITS = b2da_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [b2da_pkg::SPACE_W-1:0]    i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [VALUE_BITS-1:0]           i_value,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [b2da_pkg::CHAR_W-1:0]     o_char_code,
    output logic [b2da_pkg::DCOUNT_W-1:0]   o_digit_count,
    output logic                            o_is_last,
    output logic                            o_overflow
);
    import b2da_pkg::*;

    localparam int BW    = $clog2(VALUE_BITS + 1);
    localparam int CW    = $clog2(MAX_DIGITS + 1);
    localparam int CMP_W = (CW > SPACE_W) ? CW : SPACE_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_NORM,
        S_EMIT
    } t_state;

    t_state              r_state, n_state;
    logic [BW-1:0]       r_bits, n_bits;
    logic [CW-1:0]       r_n, n_n;
    logic [CW-1:0]       r_left, n_left;
    logic                r_ovf, n_ovf;
    logic [SPACE_W-1:0]  r_space, n_space;
    logic                r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]   r_char, n_char;
    logic [DCOUNT_W-1:0] r_cnt, n_cnt;
    logic                r_last, n_last;
    logic                r_oflag, n_oflag;

    t_bcd_ctrl           ctrl;
    logic [3:0]          top_digit;
    logic                top_zero;
    logic                sticky;
    logic                out_free;
    logic                in_acc;
    logic [CW+DCOUNT_W-1:0] n_ext;

    b2da_bcd #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_bcd (
        .i_clk       (i_clk),
        .i_ctrl      (ctrl),
        .i_value     (i_value),
        .o_top_digit (top_digit),
        .o_top_zero  (top_zero),
        .o_sticky    (sticky)
    );

    assign out_free = !r_out_valid || i_ready;
    assign in_acc   = (r_state == S_IDLE) && i_valid;
    assign n_ext    = {{DCOUNT_W{1'b0}}, r_n};

    always_comb begin
        ctrl.load        = in_acc;
        ctrl.shift_bit   = (r_state == S_CONV);
        ctrl.shift_digit = ((r_state == S_NORM) && !sticky && top_zero && (r_n > CW'(1)))
                         || ((r_state == S_EMIT) && out_free && !r_ovf);
    end

    always_comb begin
        n_state     = r_state;
        n_bits      = r_bits;
        n_n         = r_n;
        n_left      = r_left;
        n_ovf       = r_ovf;
        n_space     = r_space;
        n_out_valid = r_out_valid;
        n_char      = r_char;
        n_cnt       = r_cnt;
        n_last      = r_last;
        n_oflag     = r_oflag;

        if (i_cfg_we) begin
            n_space = i_cfg_data;
        end
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_bits  = BW'(VALUE_BITS);
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                n_bits = r_bits - BW'(1);
                if (r_bits == BW'(1)) begin
                    n_n     = CW'(MAX_DIGITS);
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                if (sticky) begin
                    n_ovf   = 1'b1;
                    n_state = S_EMIT;
                end else if (top_zero && (r_n > CW'(1))) begin
                    n_n = r_n - CW'(1);
                end else begin
                    n_ovf   = CMP_W'(r_n) > CMP_W'(r_space);
                    n_left  = r_n;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_ovf) begin
                        n_char  = ASCII_ZERO;
                        n_cnt   = '0;
                        n_last  = 1'b1;
                        n_oflag = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_char  = ASCII_ZERO + {{(CHAR_W-4){1'b0}}, top_digit};
                        n_cnt   = n_ext[DCOUNT_W-1:0];
                        n_last  = (r_left == CW'(1));
                        n_oflag = 1'b0;
                        n_left  = r_left - CW'(1);
                        if (r_left == CW'(1)) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_space     <= SPACE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_space     <= n_space;
            r_out_valid <= n_out_valid;
        end
        r_bits  <= n_bits;
        r_n     <= n_n;
        r_left  <= n_left;
        r_ovf   <= n_ovf;
        r_char  <= n_char;
        r_cnt   <= n_cnt;
        r_last  <= n_last;
        r_oflag <= n_oflag;
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_char_code   = r_char;
    assign o_digit_count = r_cnt;
    assign o_is_last     = r_last;
    assign o_overflow    = r_oflag;

endmodule

FILE: rtl/b2da_bcd.sv
`timescale 1ns / 1ps

module b2da_bcd #(
    parameter int VALUE_BITS = b2da_pkg::VALUE_BITS_DEF,
    parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF
) (
    input  logic                  i_clk,
    input  b2da_pkg::t_bcd_ctrl   i_ctrl,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic [3:0]            o_top_digit,
    output logic                  o_top_zero,
    output logic                  o_sticky
);
    import b2da_pkg::*;

    localparam int BCD_W = 4 * MAX_DIGITS;

    logic [VALUE_BITS-1:0] r_bin;
    logic [VALUE_BITS-1:0] n_bin;
    logic [BCD_W-1:0]      r_bcd;
    logic [BCD_W-1:0]      n_bcd;
    logic [BCD_W-1:0]      adj;
    logic                  r_sticky;
    logic                  n_sticky;

    // add-3 correction on every digit that is 5 or more
    always_comb begin
        for (int d = 0; d < MAX_DIGITS; d++) begin
            if (r_bcd[4*d +: 4] >= 4'd5) begin
                adj[4*d +: 4] = r_bcd[4*d +: 4] + 4'd3;
            end else begin
                adj[4*d +: 4] = r_bcd[4*d +: 4];
            end
        end
    end

    always_comb begin
        n_bin    = r_bin;
        n_bcd    = r_bcd;
        n_sticky = r_sticky;
        if (i_ctrl.load) begin
            n_bin    = i_value;
            n_bcd    = '0;
            n_sticky = 1'b0;
        end else if (i_ctrl.shift_bit) begin
            n_bin    = {r_bin[VALUE_BITS-2:0], 1'b0};
            n_bcd    = {adj[BCD_W-2:0], r_bin[VALUE_BITS-1]};
            // a one leaving the top digit means more digits than we hold
            n_sticky = r_sticky | adj[BCD_W-1];
        end else if (i_ctrl.shift_digit) begin
            n_bcd = {r_bcd[BCD_W-5:0], 4'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin    <= n_bin;
        r_bcd    <= n_bcd;
        r_sticky <= n_sticky;
    end

    assign o_top_digit = r_bcd[BCD_W-1 -: 4];
    assign o_top_zero  = (r_bcd[BCD_W-1 -: 4] == 4'd0);
    assign o_sticky    = r_sticky;

endmodule

FILE: rtl/b2da_chk.sv
`timescale 1ns / 1ps

module b2da_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [b2da_pkg::CHAR_W-1:0]   o_char_code,
    input logic [b2da_pkg::DCOUNT_W-1:0] o_digit_count,
    input logic                          o_is_last,
    input logic                          o_overflow
);
    import b2da_pkg::*;

    // a stalled result item keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_char_code)
            && $stable(o_digit_count) && $stable(o_is_last) && $stable(o_overflow)))
        else $error("output item changed while stalled");

    a_ovf_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |-> (o_is_last && (o_digit_count == '0)
            && (o_char_code == ASCII_ZERO)))
        else $error("malformed overflow item");

    a_digit_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_overflow) |-> ((o_digit_count != '0)
            && (o_char_code >= ASCII_ZERO) && (o_char_code <= ASCII_ZERO + 6'd9)))
        else $error("malformed digit item");

    // after an accept the block is converting, so input is never taken twice in a row
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input taken while converting");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind binary_to_decimal_ascii b2da_chk u_b2da_chk (.*);
